FILE: hw/rtl/fqrr_pkg.sv
// ----------------------------------------------------------------------------
// fqrr_pkg
// Shared types and codes for the fair-queue round-robin arbiter.
// ----------------------------------------------------------------------------
package fqrr_pkg;

  typedef enum logic [2:0] {
    OP_ATTACH  = 3'd0,
    OP_DETACH  = 3'd1,
    OP_KILL    = 3'd2,
    OP_REVIVE  = 3'd3,
    OP_RECEIVE = 3'd4,
    OP_PEEK    = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  pipe_id;
    logic [15:0] ready_mask;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [3:0] granted_pipe;
    logic       error;
  } out_item_t;

  // Datapath commands, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SET_ERR,
    CMD_FIND_START,
    CMD_FIND_RD,
    CMD_IDX_INC,
    CMD_PLAN,
    CMD_RD_B,
    CMD_WR_A,
    CMD_WR_B,
    CMD_SCAN_START,
    CMD_SCAN_RD,
    CMD_SCAN_STEP,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;        // slot list holds MAX_PIPES entries
    logic       empty;       // no slots in use
    logic       match;       // slot read back equals the requested id
    logic       idx_last;    // search index is on the last used slot
    logic       idx_active;  // search index lies in the active front
    logic       wr2;         // planned move needs a second write
    logic       scan_done;   // no active slots left to examine
    logic       hit;         // scanned slot's source is ready
  } dp_status_t;

endpackage

FILE: hw/rtl/fqrr_datapath.sv
// ----------------------------------------------------------------------------
// fqrr_datapath
// Slot list memory, counters, cursor and result registers, driven by commands.
// ----------------------------------------------------------------------------
module fqrr_datapath
  import fqrr_pkg::*;
#(
  parameter int MAX_PIPES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  in_item_t   in_data,
  output dp_status_t status,
  output out_item_t  out_data
);

  localparam int IW = (MAX_PIPES > 1) ? $clog2(MAX_PIPES) : 1;
  localparam int CW = $clog2(MAX_PIPES + 1);

  logic [3:0]    mem [MAX_PIPES];
  logic [3:0]    rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          rd_en;

  logic [2:0]    op_r;
  logic [3:0]    id_r;
  logic [15:0]   mask_r;
  logic [CW-1:0] slot_count_r;
  logic [CW-1:0] active_count_r;
  logic [IW-1:0] cursor_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] a_r;
  logic [IW-1:0] b_r;
  logic          wr2_r;
  logic [CW-1:0] n_r;
  logic          found_r;
  logic [3:0]    granted_r;
  logic          err_r;
  out_item_t     out_r;

  logic [CW-1:0] cursor_inc;
  logic [CW-1:0] idx_inc;
  logic          hit;

  assign cursor_inc = CW'(cursor_r) + CW'(1);
  assign idx_inc    = CW'(idx_r) + CW'(1);
  assign hit        = mask_r[rd_data_r];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r;
    unique case (cmd)
      CMD_FIND_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r;
      end
      CMD_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = b_r;
      end
      CMD_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = cursor_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd == CMD_WR_A) begin
      mem[a_r] <= rd_data_r;
    end else if (cmd == CMD_WR_B) begin
      mem[b_r] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r   <= '0;
      active_count_r <= '0;
      cursor_r       <= '0;
      op_r           <= '0;
      wr2_r          <= 1'b0;
      found_r        <= 1'b0;
      err_r          <= 1'b0;
      granted_r      <= '0;
    end else begin
      unique case (cmd)
        CMD_LOAD: begin
          op_r      <= in_data.op;
          id_r      <= in_data.pipe_id;
          mask_r    <= in_data.ready_mask;
          found_r   <= 1'b0;
          err_r     <= 1'b0;
          granted_r <= '0;
        end
        CMD_SET_ERR: begin
          err_r <= 1'b1;
        end
        CMD_FIND_START: begin
          idx_r <= '0;
        end
        CMD_IDX_INC: begin
          idx_r <= idx_inc[IW-1:0];
        end
        CMD_PLAN: begin
          // Moves are: slot A takes slot B, then optionally slot B takes the id
          priority if (op_r == OP_ATTACH) begin
            a_r            <= slot_count_r[IW-1:0];
            b_r            <= active_count_r[IW-1:0];
            wr2_r          <= 1'b1;
            slot_count_r   <= slot_count_r + CW'(1);
            active_count_r <= active_count_r + CW'(1);
          end else if (op_r == OP_DETACH) begin
            a_r          <= idx_r;
            b_r          <= IW'(slot_count_r - CW'(1));
            wr2_r        <= 1'b0;
            slot_count_r <= slot_count_r - CW'(1);
            if (CW'(idx_r) < active_count_r) begin
              active_count_r <= active_count_r - CW'(1);
            end
          end else if (op_r == OP_KILL) begin
            a_r            <= idx_r;
            b_r            <= IW'(active_count_r - CW'(1));
            wr2_r          <= 1'b1;
            active_count_r <= active_count_r - CW'(1);
          end else begin
            a_r            <= idx_r;
            b_r            <= active_count_r[IW-1:0];
            wr2_r          <= 1'b1;
            active_count_r <= active_count_r + CW'(1);
          end
        end
        CMD_SCAN_START: begin
          if (CW'(cursor_r) >= active_count_r) begin
            cursor_r <= '0;
          end
          n_r <= active_count_r;
        end
        CMD_SCAN_STEP: begin
          if (hit) begin
            found_r   <= 1'b1;
            granted_r <= rd_data_r;
          end
          // peek leaves the cursor on the ready source
          if (!(hit && op_r == OP_PEEK)) begin
            cursor_r <= (cursor_inc >= active_count_r) ? '0 : cursor_inc[IW-1:0];
          end
          n_r <= n_r - CW'(1);
        end
        CMD_FINISH: begin
          out_r.found        <= found_r;
          out_r.granted_pipe <= granted_r;
          out_r.error        <= err_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status.op         = op_r;
    status.full       = (slot_count_r == CW'(MAX_PIPES));
    status.empty      = (slot_count_r == '0);
    status.match      = (rd_data_r == id_r);
    status.idx_last   = (idx_inc == slot_count_r);
    status.idx_active = (CW'(idx_r) < active_count_r);
    status.wr2        = wr2_r;
    status.scan_done  = (n_r == '0);
    status.hit        = hit;
  end

  assign out_data = out_r;

endmodule

FILE: hw/rtl/fqrr_ctrl.sv
// ----------------------------------------------------------------------------
// fqrr_ctrl
// Sequencer for the arbiter: decodes the op and steps the datapath.
// ----------------------------------------------------------------------------
module fqrr_ctrl
  import fqrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_MOVE_WR2,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (status.op == OP_ATTACH) begin
          if (status.full) begin
            cmd       = CMD_SET_ERR;
            state_nxt = S_FINISH;
          end else begin
            cmd       = CMD_PLAN;
            state_nxt = S_MOVE_RD;
          end
        end else if (status.op == OP_DETACH || status.op == OP_KILL ||
                     status.op == OP_REVIVE) begin
          if (status.empty) begin
            cmd       = CMD_SET_ERR;
            state_nxt = S_FINISH;
          end else begin
            cmd       = CMD_FIND_START;
            state_nxt = S_FIND_RD;
          end
        end else if (status.op == OP_RECEIVE || status.op == OP_PEEK) begin
          cmd       = CMD_SCAN_START;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FIND_RD: begin
        cmd       = CMD_FIND_RD;
        state_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (status.match) begin
          priority if (status.op == OP_DETACH) begin
            cmd       = CMD_PLAN;
            state_nxt = S_MOVE_RD;
          end else if (status.op == OP_KILL && status.idx_active) begin
            cmd       = CMD_PLAN;
            state_nxt = S_MOVE_RD;
          end else if (status.op == OP_REVIVE && !status.idx_active) begin
            cmd       = CMD_PLAN;
            state_nxt = S_MOVE_RD;
          end else begin
            // already in the requested group: nothing to move
            state_nxt = S_FINISH;
          end
        end else if (status.idx_last) begin
          cmd       = CMD_SET_ERR;
          state_nxt = S_FINISH;
        end else begin
          cmd       = CMD_IDX_INC;
          state_nxt = S_FIND_RD;
        end
      end
      S_MOVE_RD: begin
        cmd       = CMD_RD_B;
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd       = CMD_WR_A;
        state_nxt = status.wr2 ? S_MOVE_WR2 : S_FINISH;
      end
      S_MOVE_WR2: begin
        cmd       = CMD_WR_B;
        state_nxt = S_FINISH;
      end
      S_SCAN_RD: begin
        if (status.scan_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd       = CMD_SCAN_RD;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd       = CMD_SCAN_STEP;
        state_nxt = status.hit ? S_FINISH : S_SCAN_RD;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd       = CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd == CMD_FINISH) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/fair_queue_round_robin_arbiter_top.sv
// Attach plans and moves a slot, or flags an error when the table is full; detach/kill/revive
//   search the slot list slot by slot, then move if needed; receive/peek examine active slots in
//   turn until a ready source is found; undefined ops go straight to the result.
// One op in flight; a new op is taken while the previous result waits in the output register.
//   Synchronous active-low reset empties the slot list and zeroes the cursor; slot memory is
//   not cleared.
// ----------------------------------------------------------------------------
// fair_queue_round_robin_arbiter_top
// Round-robin fair-queue arbiter over an ordered list of source ids.
// ----------------------------------------------------------------------------
module fair_queue_round_robin_arbiter_top
  import fqrr_pkg::*;
#(
  parameter int MAX_PIPES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t       cmd;
  dp_status_t status;

  fqrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fqrr_datapath #(
    .MAX_PIPES (MAX_PIPES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule
